[rtl/dle_stuffed_command_framer_defines.svh]
// ----------------------------------------------------------------------------
// dle_stuffed_command_framer_defines
// Assertion macros used by the framer RTL (dsf_back).
// ----------------------------------------------------------------------------
`ifndef DLE_STUFFED_COMMAND_FRAMER_DEFINES_SVH
`define DLE_STUFFED_COMMAND_FRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, checked out of reset.
`define DSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[rtl/dsf_pkg.sv]
// ----------------------------------------------------------------------------
// dsf_pkg
// Types, byte codes and register indexes of the DLE command framer.
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int DSF_QDEPTH = 2;

    localparam logic [7:0] HEAD_BYTE    = 8'h02;
    localparam logic [7:0] ESCAPE_BYTE  = 8'h10;
    localparam logic [7:0] TRAILER_BYTE = 8'h03;

    // register index = paddr[2]
    localparam int         PADDR_W       = 3;
    localparam logic       REG_ADDR_HIGH = 1'b0;
    localparam logic       REG_ADDR_LOW  = 1'b1;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       run_last;
        logic       frame_end;
    } t_out_beat;

    // one classified payload byte, queued between front and back
    typedef struct packed {
        logic       open_frame;
        logic       escape;
        logic       last;
        logic [7:0] addr_high;
        logic [7:0] addr_low;
        logic [7:0] data;
        logic [7:0] sum;
    } t_cmd;

    function automatic logic needs_escape(input logic [7:0] b);
        needs_escape = (b == HEAD_BYTE) || (b == ESCAPE_BYTE) || (b == TRAILER_BYTE);
    endfunction

endpackage

[rtl/dsf_front.sv]
// ----------------------------------------------------------------------------
// dsf_front
// Accepts payload beats, tracks frame state and checksum, classifies bytes.
// ----------------------------------------------------------------------------
module dsf_front import dsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_beat   i_in_beat,
    input  logic [7:0] i_addr_high,
    input  logic [7:0] i_addr_low,
    input  logic       i_q_full,
    output logic       o_stall,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic       r_inside;
    logic       n_inside;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [7:0] sum_now;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign sum_now = r_sum + i_in_beat.payload_byte;

    always_comb begin
        o_cmd.open_frame = !r_inside;
        o_cmd.escape     = needs_escape(i_in_beat.payload_byte);
        o_cmd.last       = i_in_beat.payload_last;
        o_cmd.addr_high  = i_addr_high;
        o_cmd.addr_low   = i_addr_low;
        o_cmd.data       = i_in_beat.payload_byte;
        o_cmd.sum        = sum_now;
    end

    always_comb begin
        n_inside = r_inside;
        n_sum    = r_sum;
        if (o_push) begin
            n_inside = !i_in_beat.payload_last;
            n_sum    = i_in_beat.payload_last ? 8'h00 : sum_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_sum    <= 8'h00;
        end else begin
            r_inside <= n_inside;
            r_sum    <= n_sum;
        end
    end

endmodule

[rtl/dsf_queue.sv]
// ----------------------------------------------------------------------------
// dsf_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module dsf_queue import dsf_pkg::*; #(
    parameter int DEPTH = DSF_QDEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/dsf_back.sv]
// ----------------------------------------------------------------------------
// dsf_back
// Walks each queued byte through its frame steps into the output register.
// ----------------------------------------------------------------------------
`include "dle_stuffed_command_framer_defines.svh"

module dsf_back import dsf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_beat o_out_beat,
    input  logic      i_stall
);

    localparam logic [2:0] ST_HEAD  = 3'd0;
    localparam logic [2:0] ST_AHIGH = 3'd1;
    localparam logic [2:0] ST_ALOW  = 3'd2;
    localparam logic [2:0] ST_ESC   = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_TRAIL = 3'd6;

    logic       r_mid;
    logic [2:0] r_step;
    logic       r_out_valid;
    t_out_beat  r_out;

    logic       load;
    logic       done;
    logic [2:0] step_now;
    logic [2:0] step_next;
    t_out_beat  beat;

    assign load = i_cmd_valid && (!r_out_valid || !i_stall);

    always_comb begin
        if (r_mid) begin
            step_now = r_step;
        end else if (i_cmd.open_frame) begin
            step_now = ST_HEAD;
        end else if (i_cmd.escape) begin
            step_now = ST_ESC;
        end else begin
            step_now = ST_DATA;
        end
    end

    always_comb begin
        beat.frame_byte = 8'h00;
        beat.frame_end  = 1'b0;
        done            = 1'b0;
        step_next       = ST_DATA;
        case (step_now)
            ST_HEAD: begin
                beat.frame_byte = HEAD_BYTE;
                step_next       = ST_AHIGH;
            end
            ST_AHIGH: begin
                beat.frame_byte = i_cmd.addr_high;
                step_next       = ST_ALOW;
            end
            ST_ALOW: begin
                beat.frame_byte = i_cmd.addr_low;
                step_next       = i_cmd.escape ? ST_ESC : ST_DATA;
            end
            ST_ESC: begin
                beat.frame_byte = ESCAPE_BYTE;
                step_next       = ST_DATA;
            end
            ST_DATA: begin
                beat.frame_byte = i_cmd.data;
                done            = !i_cmd.last;
                step_next       = ST_SUM;
            end
            ST_SUM: begin
                beat.frame_byte = i_cmd.sum;   // checksum goes out unescaped
                step_next       = ST_TRAIL;
            end
            ST_TRAIL: begin
                beat.frame_byte = TRAILER_BYTE;
                beat.frame_end  = 1'b1;
                done            = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
        beat.run_last = done;
    end

    assign o_pop      = load && done;
    assign o_valid    = r_out_valid;
    assign o_out_beat = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_step      <= ST_HEAD;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_mid  <= !done;
                r_step <= step_next;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `DSF_ASSERT_NOW(a_mid_has_cmd, i_clk, i_rst_n, r_mid, i_cmd_valid)
    `DSF_ASSERT_NOW(a_end_is_trailer, i_clk, i_rst_n, r_out_valid && r_out.frame_end,
        r_out.run_last && (r_out.frame_byte == TRAILER_BYTE))
    `DSF_ASSERT_NEXT(a_trailer_closes, i_clk, i_rst_n, load && (step_now == ST_TRAIL),
        !r_mid && o_valid && o_out_beat.frame_end)

endmodule

[rtl/dle_stuffed_command_framer.sv]
// ----------------------------------------------------------------------------
// dle_stuffed_command_framer
// DLE byte-stuffing command framer with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one payload byte per beat (i_valid / o_stall), with
//   payload_last on the final byte of a command. Output channel: one frame
//   byte per beat (o_valid / i_stall). The first byte of a command opens a
//   frame: head 0x02, address high, address low. Bytes equal to 0x02, 0x10
//   or 0x03 get a 0x10 escape in front. After the last byte the running
//   sum and the 0x03 trailer follow; frame_end marks the trailer and
//   run_last marks the final output beat caused by each input beat.
//   An accepted input beat is written into the queue at the accepting edge;
//   its output beats then load from the queue head into the output register,
//   and o_valid rises once the first is loaded. While i_stall is low the
//   output takes one beat per cycle; an input makes one output beat (plain),
//   two (escaped), up to seven (single-byte frame), and its queue entry is
//   popped as its last beat loads. A queue of QDEPTH entries (two by default)
//   between the classifier and the sequencer lets input beats be taken while
//   earlier bytes are still being sent or stalled. When i_stall is high the
//   output beat holds; once the queue fills, o_stall rises. Reset clears
//   frame state, checksum, queue and output valid; address registers reset
//   to 0 and are written over APB at byte addresses 0 (high) and 4 (low).
//   The user must write them only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module dle_stuffed_command_framer import dsf_pkg::*; #(
    parameter int QDEPTH = DSF_QDEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // payload input
    input  logic               i_valid,
    input  t_in_beat           i_in_beat,
    output logic               o_stall,
    // frame output
    output logic               o_valid,
    output t_out_beat          o_out_beat,
    input  logic               i_stall,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] r_addr_high;
    logic [7:0] r_addr_low;
    logic       cfg_write;
    logic       reg_sel;

    logic       q_full;
    logic       q_push;
    t_cmd       q_in;
    logic       q_valid;
    t_cmd       q_out;
    logic       q_pop;

    // register file; index is the word address bit
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_sel == REG_ADDR_HIGH) ? {24'h0, r_addr_high} : {24'h0, r_addr_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_high <= 8'h00;
            r_addr_low  <= 8'h00;
        end else if (cfg_write) begin
            if (reg_sel == REG_ADDR_HIGH) begin
                r_addr_high <= pwdata[7:0];
            end else begin
                r_addr_low <= pwdata[7:0];
            end
        end
    end

    // front: accept, classify, checksum
    dsf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_beat   (i_in_beat),
        .i_addr_high (r_addr_high),
        .i_addr_low  (r_addr_low),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    // decoupling queue
    dsf_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    // back: byte sequencer and output register
    dsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .o_out_beat  (o_out_beat),
        .i_stall     (i_stall)
    );

endmodule
